>>> sv/i2cbm_pkg.sv
`default_nettype none

package i2cbm_pkg;

    localparam int HALF_W = 16;
    localparam int TMO_W  = 8;
    localparam int CFG_W  = HALF_W;

    localparam logic [HALF_W-1:0] HALF_RESET = 16'd6;
    localparam logic [TMO_W-1:0]  TMO_RESET  = 8'd250;

    // configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    // command codes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_WACK  = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       ack_after_read;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } out_item_t;

endpackage

`default_nettype wire

>>> sv/i2cbm_in_if.sv
`default_nettype none

interface i2cbm_in_if
    import i2cbm_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/i2cbm_out_if.sv
`default_nettype none

interface i2cbm_out_if
    import i2cbm_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/i2c_bit_level_master.sv
// An accepted tick's result is registered in the output register as it is taken.
// Throughput: one tick per cycle; a tick is taken whenever the output register
// is empty or is being read in the same cycle.
// Reset (rst_n low, asynchronous): sequencer idle, SCL high, SDA released,
// received byte and failure flag cleared, half period 6, ACK timeout 250.
`default_nettype none

module i2c_bit_level_master
    import i2cbm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    i2cbm_in_if.sink               in_ch,
    i2cbm_out_if.source            out_ch,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_ST_A = 4'd1;
    localparam logic [3:0] PH_ST_B = 4'd2;
    localparam logic [3:0] PH_SP_A = 4'd3;
    localparam logic [3:0] PH_SP_B = 4'd4;
    localparam logic [3:0] PH_WD   = 4'd5;
    localparam logic [3:0] PH_WH   = 4'd6;
    localparam logic [3:0] PH_WL   = 4'd7;
    localparam logic [3:0] PH_RL   = 4'd8;
    localparam logic [3:0] PH_RH   = 4'd9;
    localparam logic [3:0] PH_AL   = 4'd10;
    localparam logic [3:0] PH_AH   = 4'd11;
    localparam logic [3:0] PH_KA   = 4'd12;
    localparam logic [3:0] PH_KH   = 4'd13;
    localparam logic [3:0] PH_KP   = 4'd14;

    logic [HALF_W-1:0] half_reg;
    logic [TMO_W-1:0]  tmo_reg;

    logic [3:0]        phase_reg, phase_next;
    logic [3:0]        bit_reg, bit_next;
    logic [7:0]        shift_reg, shift_next;
    logic [HALF_W-1:0] delay_reg, delay_next;
    logic [TMO_W-1:0]  tcount_reg, tcount_next;
    logic              fail_reg, fail_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              drv_reg, drv_next;
    logic [7:0]        rx_reg, rx_next;
    logic              ackc_reg, ackc_next;
    logic              done;

    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic              accept;
    logic [HALF_W-1:0] half_eff;
    in_item_t          item;

    assign item     = in_ch.data;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept   = in_ch.valid && in_ch.ready;
    assign half_eff = (half_reg == '0) ? HALF_W'(1) : half_reg;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_RESET;
            tmo_reg  <= TMO_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_HALF_PERIOD)
                half_reg <= cfg_data;
            else
                tmo_reg <= cfg_data[TMO_W-1:0];
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        delay_next  = delay_reg;
        tcount_next = tcount_reg;
        fail_next   = fail_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        drv_next    = drv_reg;
        rx_next     = rx_reg;
        ackc_next   = ackc_reg;
        done        = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            bit_next = '0;
            unique case (item.op)
                OP_START:
                begin
                    scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b1;
                    phase_next = PH_ST_A; delay_next = half_eff;
                end
                OP_STOP:
                begin
                    scl_next = 1'b0; sda_next = 1'b0; drv_next = 1'b1;
                    phase_next = PH_SP_A; delay_next = half_eff;
                end
                OP_WRITE:
                begin
                    shift_next = item.tx_byte;
                    scl_next = 1'b0; sda_next = item.tx_byte[7]; drv_next = 1'b1;
                    phase_next = PH_WD; delay_next = half_eff;
                end
                OP_READ:
                begin
                    shift_next = '0;
                    ackc_next  = item.ack_after_read;
                    scl_next = 1'b0; sda_next = 1'b1; drv_next = 1'b0;
                    phase_next = PH_RL; delay_next = half_eff;
                end
                OP_WACK:
                begin
                    tcount_next = '0;
                    sda_next = 1'b1; drv_next = 1'b0;
                    phase_next = PH_KA; delay_next = half_eff;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else if (phase_reg == PH_KP)
        begin
            if (!item.sda_in)
            begin
                scl_next = 1'b0; sda_next = 1'b1; drv_next = 1'b0;
                fail_next  = 1'b0;
                phase_next = PH_IDLE;
                done       = 1'b1;
            end
            else if (tcount_reg >= tmo_reg)
            begin
                // timed out: flag it and run a full stop
                fail_next = 1'b1;
                scl_next = 1'b0; sda_next = 1'b0; drv_next = 1'b1;
                phase_next = PH_SP_A; delay_next = half_eff;
            end
            else
            begin
                tcount_next = tcount_reg + TMO_W'(1);
            end
        end
        else if (delay_reg > HALF_W'(1))
        begin
            delay_next = delay_reg - HALF_W'(1);
        end
        else
        begin
            unique case (phase_reg)
                PH_ST_A:
                begin
                    scl_next = 1'b1; sda_next = 1'b0; drv_next = 1'b1;
                    phase_next = PH_ST_B; delay_next = half_eff;
                end
                PH_ST_B:
                begin
                    scl_next = 1'b0; sda_next = 1'b0; drv_next = 1'b1;
                    phase_next = PH_IDLE; done = 1'b1;
                end
                PH_SP_A:
                begin
                    scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b1;
                    phase_next = PH_SP_B; delay_next = half_eff;
                end
                PH_WD:
                begin
                    scl_next = 1'b1; drv_next = 1'b1;
                    phase_next = PH_WH; delay_next = half_eff;
                end
                PH_WH:
                begin
                    scl_next = 1'b0; drv_next = 1'b1;
                    phase_next = PH_WL; delay_next = half_eff;
                end
                PH_WL:
                begin
                    bit_next = bit_reg + 4'd1;
                    if (bit_next[3])
                    begin
                        phase_next = PH_IDLE; done = 1'b1;
                    end
                    else
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        scl_next = 1'b0; sda_next = shift_reg[6]; drv_next = 1'b1;
                        phase_next = PH_WD; delay_next = half_eff;
                    end
                end
                PH_RL:
                begin
                    // sample on the rising SCL tick
                    scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b0;
                    shift_next = {shift_reg[6:0], item.sda_in};
                    phase_next = PH_RH; delay_next = half_eff;
                end
                PH_RH:
                begin
                    bit_next = bit_reg + 4'd1;
                    if (bit_next[3])
                    begin
                        rx_next  = shift_reg;
                        scl_next = 1'b0; sda_next = !ackc_reg; drv_next = 1'b1;
                        phase_next = PH_AL; delay_next = half_eff;
                    end
                    else
                    begin
                        scl_next = 1'b0; sda_next = 1'b1; drv_next = 1'b0;
                        phase_next = PH_RL; delay_next = half_eff;
                    end
                end
                PH_AL:
                begin
                    scl_next = 1'b1; drv_next = 1'b1;
                    phase_next = PH_AH; delay_next = half_eff;
                end
                PH_AH:
                begin
                    scl_next = 1'b0; drv_next = 1'b1;
                    phase_next = PH_IDLE; done = 1'b1;
                end
                PH_KA:
                begin
                    scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b0;
                    phase_next = PH_KH; delay_next = half_eff;
                end
                PH_KH:
                begin
                    phase_next = PH_KP; delay_next = '0;
                end
                default:
                begin
                    phase_next = PH_IDLE; done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bit_reg    <= '0;
            shift_reg  <= '0;
            delay_reg  <= '0;
            tcount_reg <= '0;
            fail_reg   <= 1'b0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            drv_reg    <= 1'b0;
            rx_reg     <= '0;
            ackc_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            delay_reg  <= delay_next;
            tcount_reg <= tcount_next;
            fail_reg   <= fail_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            drv_reg    <= drv_next;
            rx_reg     <= rx_next;
            ackc_reg   <= ackc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.scl_level  <= scl_next;
            out_data_reg.sda_level  <= sda_next;
            out_data_reg.sda_drive  <= drv_next;
            out_data_reg.busy_res   <= (phase_next != PH_IDLE);
            out_data_reg.done_res   <= done;
            out_data_reg.rx_byte    <= rx_next;
            out_data_reg.ack_failed <= fail_next;
        end
    end

endmodule

`default_nettype wire
